@@ hdl/slc_pkg.sv @@
// Shared types, character codes and result codes for the source line counter.
package slc_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 24;

	typedef enum logic [3:0] {
		LS_NEW_LINE       = 4'd0,
		LS_NEW_LINE_NC    = 4'd1,
		LS_POS_COMMENT    = 4'd2,
		LS_LINE_COMMENT   = 4'd3,
		LS_BLOCK_COMMENT  = 4'd4,
		LS_POS_END_COMM   = 4'd5,
		LS_END_COMMENT    = 4'd6,
		LS_DIRECTIVE      = 4'd7,
		LS_CODE           = 4'd8,
		LS_OPEN_BRACE     = 4'd9,
		LS_CLOSE_BRACE1   = 4'd10,
		LS_CLOSE_BRACE2   = 4'd11,
		LS_POS_EOL        = 4'd12,
		LS_TRAIL_COMMENT  = 4'd13
	} line_state_t;

	typedef enum logic [1:0] {
		FS_NONE     = 2'd0,
		FS_POSSIBLE = 2'd1,
		FS_INSIDE   = 2'd2
	} func_state_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic RK_RECORD  = 1'b0;
	localparam logic RK_SUMMARY = 1'b1;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

@@ hdl/slc_if.sv @@
// Valid/ready channels for source bytes and counter results.
interface slc_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface slc_result_if #(
	parameter int unsigned COUNT_WIDTH = slc_pkg::COUNT_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   result_kind;
	logic [COUNT_WIDTH-1:0] function_lines;
	logic [COUNT_WIDTH-1:0] function_total;
	logic [COUNT_WIDTH-1:0] lines_in_functions;
	logic [COUNT_WIDTH-1:0] program_lines;
	logic                   last;

	modport source (output valid, output result_kind, output function_lines,
		output function_total, output lines_in_functions, output program_lines,
		output last, input ready);
	modport sink (input valid, input result_kind, input function_lines,
		input function_total, input lines_in_functions, input program_lines,
		input last, output ready);
endinterface

@@ hdl/source_line_of_code_counter.sv @@
// Source line counter: byte-wise C comment/brace machine with line and function totals.
// One request (a source byte or an end-of-stream marker) is taken every clock cycle.
// A request is held in an input register while the character machine, the line
// rules and the saturating counters update; any function record or summary it
// causes goes into a four-entry result queue, and a result is visible once its
// request has passed the input register and been written into the queue. A request
// causes at most two results; the input stalls only while the queue has fewer than
// two free entries, i.e. when the result side holds off. The end-of-stream summary
// returns every counter and state to its reset value, so the next stream starts clean.
module source_line_of_code_counter #(
	parameter int unsigned COUNT_WIDTH = slc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	slc_item_if.sink            item,
	slc_result_if.source        result
);

	typedef struct packed {
		logic                   result_kind;
		logic [COUNT_WIDTH-1:0] function_lines;
		logic [COUNT_WIDTH-1:0] function_total;
		logic [COUNT_WIDTH-1:0] lines_in_functions;
		logic [COUNT_WIDTH-1:0] program_lines;
		logic                   last;
	} res_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : COUNT_WIDTH'(v + 1'b1);
	endfunction

	function automatic slc_pkg::line_state_t next_ls(input slc_pkg::line_state_t s,
			input logic [7:0] c);
		slc_pkg::line_state_t n;
		logic ws;
		ws = (c == slc_pkg::CH_SPACE) || ((c >= slc_pkg::CH_TAB) && (c <= slc_pkg::CH_CR));
		unique case (s)
			slc_pkg::LS_NEW_LINE_NC: n = slc_pkg::LS_NEW_LINE_NC;
			slc_pkg::LS_POS_COMMENT: begin
				if (c == slc_pkg::CH_SLASH)
					n = slc_pkg::LS_LINE_COMMENT;
				else if (c == slc_pkg::CH_STAR)
					n = slc_pkg::LS_BLOCK_COMMENT;
				else
					n = slc_pkg::LS_NEW_LINE_NC;
			end
			slc_pkg::LS_LINE_COMMENT:
				n = (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE_NC : slc_pkg::LS_LINE_COMMENT;
			slc_pkg::LS_BLOCK_COMMENT:
				n = (c == slc_pkg::CH_STAR) ? slc_pkg::LS_POS_END_COMM : slc_pkg::LS_BLOCK_COMMENT;
			slc_pkg::LS_POS_END_COMM: begin
				if (c == slc_pkg::CH_SLASH)
					n = slc_pkg::LS_END_COMMENT;
				else if (c == slc_pkg::CH_STAR)
					n = slc_pkg::LS_POS_END_COMM;
				else
					n = slc_pkg::LS_BLOCK_COMMENT;
			end
			slc_pkg::LS_END_COMMENT: n = slc_pkg::LS_NEW_LINE_NC;
			slc_pkg::LS_DIRECTIVE:
				n = (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE : slc_pkg::LS_DIRECTIVE;
			slc_pkg::LS_CODE: begin
				if (c == slc_pkg::CH_RBRACE)
					n = slc_pkg::LS_CLOSE_BRACE2;
				else if ((c == slc_pkg::CH_LBRACE) || (c == slc_pkg::CH_SEMI))
					n = slc_pkg::LS_POS_EOL;
				else
					n = slc_pkg::LS_CODE;
			end
			slc_pkg::LS_OPEN_BRACE: begin
				if (c == slc_pkg::CH_NL)
					n = slc_pkg::LS_NEW_LINE;
				else if (c == slc_pkg::CH_RBRACE)
					n = slc_pkg::LS_CLOSE_BRACE2;
				else
					n = slc_pkg::LS_CODE;
			end
			slc_pkg::LS_CLOSE_BRACE1:
				n = (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE_NC : slc_pkg::LS_CLOSE_BRACE2;
			slc_pkg::LS_CLOSE_BRACE2:
				n = (c == slc_pkg::CH_SEMI) ? slc_pkg::LS_POS_EOL : slc_pkg::LS_CODE;
			slc_pkg::LS_POS_EOL: begin
				if (c == slc_pkg::CH_NL)
					n = slc_pkg::LS_NEW_LINE;
				else if ((c == slc_pkg::CH_SPACE) || (c == slc_pkg::CH_TAB))
					n = slc_pkg::LS_POS_EOL;
				else if (c == slc_pkg::CH_SLASH)
					n = slc_pkg::LS_TRAIL_COMMENT;
				else
					n = slc_pkg::LS_CODE;
			end
			slc_pkg::LS_TRAIL_COMMENT:
				n = (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE : slc_pkg::LS_TRAIL_COMMENT;
			default: begin
				// new line, and the two unused codes
				if (c == slc_pkg::CH_NL)
					n = slc_pkg::LS_NEW_LINE_NC;
				else if (ws)
					n = slc_pkg::LS_NEW_LINE;
				else if (c == slc_pkg::CH_SLASH)
					n = slc_pkg::LS_POS_COMMENT;
				else if (c == slc_pkg::CH_HASH)
					n = slc_pkg::LS_DIRECTIVE;
				else if (c == slc_pkg::CH_LBRACE)
					n = slc_pkg::LS_OPEN_BRACE;
				else if (c == slc_pkg::CH_RBRACE)
					n = slc_pkg::LS_CLOSE_BRACE1;
				else
					n = slc_pkg::LS_CODE;
			end
		endcase
		return n;
	endfunction

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// counter state
	slc_pkg::line_state_t   line_state_q, line_state_d;
	slc_pkg::func_state_t   func_state_q, func_state_d;
	logic [7:0]             first_char_q, first_char_d;
	logic                   line_open_q, line_open_d;
	logic [COUNT_WIDTH-1:0] cur_lines_q, cur_lines_d;
	logic [COUNT_WIDTH-1:0] funcs_q, funcs_d;
	logic [COUNT_WIDTH-1:0] func_sum_q, func_sum_d;
	logic [COUNT_WIDTH-1:0] prog_sum_q, prog_sum_d;

	// result queue
	res_t       queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic       go;
	logic       pop;
	logic       is_byte;
	logic       do_end;
	logic       is_letter;
	logic       rec;
	logic [7:0] fc;
	logic [1:0] n_wr;
	res_t       w0, w1;
	res_t       rec_res, sum_res;

	slc_pkg::line_state_t   ls_a, ls_e;
	slc_pkg::func_state_t   fs_e;
	logic [COUNT_WIDTH-1:0] cl_e, ff_e, fsum_e, psum_e;

	assign go         = valid_s1 && (count_q <= 3'd2);
	assign item.ready = !valid_s1 || go;
	assign pop        = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.byte_value;
		end
	end

	always_comb begin
		is_byte = (kind_s1 == slc_pkg::KIND_BYTE);
		fc      = (is_byte && !line_open_q) ? byte_s1 : first_char_q;
		ls_a    = is_byte ? next_ls(line_state_q, byte_s1) : line_state_q;
		do_end  = is_byte ? (byte_s1 == slc_pkg::CH_NL) : line_open_q;
		is_letter = ((fc >= 8'h41) && (fc <= 8'h5A)) || ((fc >= 8'h61) && (fc <= 8'h7A));

		// line rules
		fs_e   = func_state_q;
		cl_e   = cur_lines_q;
		ff_e   = funcs_q;
		fsum_e = func_sum_q;
		psum_e = prog_sum_q;
		ls_e   = ls_a;
		if (is_letter) begin
			fs_e = slc_pkg::FS_POSSIBLE;
			cl_e = '0;
		end
		if (fs_e == slc_pkg::FS_POSSIBLE) begin
			if (fc == slc_pkg::CH_LBRACE) begin
				fs_e = slc_pkg::FS_INSIDE;
				ff_e = sat_inc(funcs_q);
			end else if (fc == slc_pkg::CH_RBRACE) begin
				fs_e = slc_pkg::FS_NONE;
			end
		end
		if (ls_a == slc_pkg::LS_NEW_LINE) begin
			psum_e = sat_inc(prog_sum_q);
			if (fs_e == slc_pkg::FS_INSIDE) begin
				cl_e   = sat_inc(cl_e);
				fsum_e = sat_inc(func_sum_q);
			end
		end
		if (ls_a == slc_pkg::LS_NEW_LINE_NC)
			ls_e = slc_pkg::LS_NEW_LINE;
		rec = do_end && (fs_e == slc_pkg::FS_INSIDE) && (fc == slc_pkg::CH_RBRACE);

		rec_res.result_kind        = slc_pkg::RK_RECORD;
		rec_res.function_lines     = cl_e;
		rec_res.function_total     = ff_e;
		rec_res.lines_in_functions = fsum_e;
		rec_res.program_lines      = psum_e;
		rec_res.last               = is_byte;

		sum_res.result_kind        = slc_pkg::RK_SUMMARY;
		sum_res.function_lines     = '0;
		sum_res.function_total     = do_end ? ff_e : funcs_q;
		sum_res.lines_in_functions = do_end ? fsum_e : func_sum_q;
		sum_res.program_lines      = do_end ? psum_e : prog_sum_q;
		sum_res.last               = 1'b1;

		if (rec) begin
			w0   = rec_res;
			w1   = sum_res;
			n_wr = is_byte ? 2'd1 : 2'd2;
		end else begin
			w0   = sum_res;
			w1   = sum_res;
			n_wr = is_byte ? 2'd0 : 2'd1;
		end

		// next state
		if (!is_byte) begin
			line_state_d = slc_pkg::LS_NEW_LINE;
			func_state_d = slc_pkg::FS_NONE;
			first_char_d = '0;
			line_open_d  = 1'b0;
			cur_lines_d  = '0;
			funcs_d      = '0;
			func_sum_d   = '0;
			prog_sum_d   = '0;
		end else if (do_end) begin
			line_state_d = ls_e;
			func_state_d = rec ? slc_pkg::FS_NONE : fs_e;
			first_char_d = fc;
			line_open_d  = 1'b0;
			cur_lines_d  = rec ? '0 : cl_e;
			funcs_d      = ff_e;
			func_sum_d   = fsum_e;
			prog_sum_d   = psum_e;
		end else begin
			line_state_d = ls_a;
			func_state_d = func_state_q;
			first_char_d = fc;
			line_open_d  = 1'b1;
			cur_lines_d  = cur_lines_q;
			funcs_d      = funcs_q;
			func_sum_d   = func_sum_q;
			prog_sum_d   = prog_sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_state_q <= slc_pkg::LS_NEW_LINE;
			func_state_q <= slc_pkg::FS_NONE;
			first_char_q <= '0;
			line_open_q  <= 1'b0;
			cur_lines_q  <= '0;
			funcs_q      <= '0;
			func_sum_q   <= '0;
			prog_sum_q   <= '0;
		end else if (go) begin
			line_state_q <= line_state_d;
			func_state_q <= func_state_d;
			first_char_q <= first_char_d;
			line_open_q  <= line_open_d;
			cur_lines_q  <= cur_lines_d;
			funcs_q      <= funcs_d;
			func_sum_q   <= func_sum_d;
			prog_sum_q   <= prog_sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (n_wr != 2'd0))
			queue_q[wr_ptr_q] <= w0;
		if (go && (n_wr == 2'd2))
			queue_q[2'(wr_ptr_q + 2'd1)] <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (go)
				wr_ptr_q <= 2'(wr_ptr_q + n_wr);
			if (pop)
				rd_ptr_q <= 2'(rd_ptr_q + 2'd1);
			count_q <= 3'(count_q + (go ? {1'b0, n_wr} : 3'd0) - {2'b00, pop});
		end
	end

	assign result.valid              = (count_q != 3'd0);
	assign result.result_kind        = queue_q[rd_ptr_q].result_kind;
	assign result.function_lines     = queue_q[rd_ptr_q].function_lines;
	assign result.function_total     = queue_q[rd_ptr_q].function_total;
	assign result.lines_in_functions = queue_q[rd_ptr_q].lines_in_functions;
	assign result.program_lines      = queue_q[rd_ptr_q].program_lines;
	assign result.last               = queue_q[rd_ptr_q].last;

endmodule

@@ hdl/slc_checker.sv @@
// Port-level checks for the source line counter, bound to the top level.
module slc_checker #(
	parameter int unsigned COUNT_WIDTH = slc_pkg::COUNT_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic                   res_kind,
	input logic [COUNT_WIDTH-1:0] res_function_lines,
	input logic [COUNT_WIDTH-1:0] res_function_total,
	input logic [COUNT_WIDTH-1:0] res_lines_in_functions,
	input logic                   res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_function_lines) && $stable(res_last))
		else $error("stalled result changed");

	a_summary_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == slc_pkg::RK_SUMMARY) |->
			res_last && (res_function_lines == '0))
		else $error("summary not last or carries function lines");

	a_record_has_function: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == slc_pkg::RK_RECORD) |-> (res_function_total != '0))
		else $error("function record with no function counted");

	a_record_within_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == slc_pkg::RK_RECORD) |->
			(res_function_lines <= res_lines_in_functions))
		else $error("function lines exceed running function total");

endmodule

bind source_line_of_code_counter slc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_slc_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.res_valid              (result.valid),
	.res_ready              (result.ready),
	.res_kind               (result.result_kind),
	.res_function_lines     (result.function_lines),
	.res_function_total     (result.function_total),
	.res_lines_in_functions (result.lines_in_functions),
	.res_last               (result.last)
);

@@ tb/tb.sv @@
// Testbench for source_line_of_code_counter: C text streams checked against a line-counting predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CW = slc_pkg::COUNT_WIDTH_DEF;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic          rk;
		logic [CW-1:0] flines;
		logic [CW-1:0] ftotal;
		logic [CW-1:0] fsum;
		logic [CW-1:0] plines;
		logic          last;
	} tally_t;

	logic clk;
	logic arst_n;

	slc_item_if item_ch();
	slc_result_if #(.COUNT_WIDTH(CW)) res_ch();

	source_line_of_code_counter #(.COUNT_WIDTH(CW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	tally_t      pending_tallies[$];
	logic [7:0]  text_q[$];

	// predictor copy of the counter state
	slc_pkg::line_state_t cm_state;
	slc_pkg::func_state_t cm_func;
	logic [7:0]    cm_first;
	logic          cm_open;
	logic [CW-1:0] cm_fn_lines;
	logic [CW-1:0] cm_found;
	logic [CW-1:0] cm_fn_sum;
	logic [CW-1:0] cm_prog_sum;

	int errors = 0;
	int requests = 0;
	int results_seen = 0;
	int records_seen = 0;
	int summaries_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_model();
		cm_state    = slc_pkg::LS_NEW_LINE;
		cm_func     = slc_pkg::FS_NONE;
		cm_first    = '0;
		cm_open     = 1'b0;
		cm_fn_lines = '0;
		cm_found    = '0;
		cm_fn_sum   = '0;
		cm_prog_sum = '0;
	endfunction

	function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic slc_pkg::line_state_t next_line_state(input slc_pkg::line_state_t s,
			input logic [7:0] c);
		case (s)
			slc_pkg::LS_NEW_LINE_NC: return slc_pkg::LS_NEW_LINE_NC;
			slc_pkg::LS_POS_COMMENT: begin
				if (c == slc_pkg::CH_SLASH) return slc_pkg::LS_LINE_COMMENT;
				if (c == slc_pkg::CH_STAR) return slc_pkg::LS_BLOCK_COMMENT;
				return slc_pkg::LS_NEW_LINE_NC;
			end
			slc_pkg::LS_LINE_COMMENT:
				return (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE_NC : slc_pkg::LS_LINE_COMMENT;
			slc_pkg::LS_BLOCK_COMMENT:
				return (c == slc_pkg::CH_STAR) ? slc_pkg::LS_POS_END_COMM
					: slc_pkg::LS_BLOCK_COMMENT;
			slc_pkg::LS_POS_END_COMM: begin
				if (c == slc_pkg::CH_SLASH) return slc_pkg::LS_END_COMMENT;
				if (c == slc_pkg::CH_STAR) return slc_pkg::LS_POS_END_COMM;
				return slc_pkg::LS_BLOCK_COMMENT;
			end
			slc_pkg::LS_END_COMMENT: return slc_pkg::LS_NEW_LINE_NC;
			slc_pkg::LS_DIRECTIVE:
				return (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE : slc_pkg::LS_DIRECTIVE;
			slc_pkg::LS_CODE: begin
				if (c == slc_pkg::CH_RBRACE) return slc_pkg::LS_CLOSE_BRACE2;
				if (c == slc_pkg::CH_LBRACE || c == slc_pkg::CH_SEMI) return slc_pkg::LS_POS_EOL;
				return slc_pkg::LS_CODE;
			end
			slc_pkg::LS_OPEN_BRACE: begin
				if (c == slc_pkg::CH_NL) return slc_pkg::LS_NEW_LINE;
				if (c == slc_pkg::CH_RBRACE) return slc_pkg::LS_CLOSE_BRACE2;
				return slc_pkg::LS_CODE;
			end
			slc_pkg::LS_CLOSE_BRACE1:
				return (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE_NC : slc_pkg::LS_CLOSE_BRACE2;
			slc_pkg::LS_CLOSE_BRACE2:
				return (c == slc_pkg::CH_SEMI) ? slc_pkg::LS_POS_EOL : slc_pkg::LS_CODE;
			slc_pkg::LS_POS_EOL: begin
				if (c == slc_pkg::CH_NL) return slc_pkg::LS_NEW_LINE;
				if (c == slc_pkg::CH_SPACE || c == slc_pkg::CH_TAB) return slc_pkg::LS_POS_EOL;
				if (c == slc_pkg::CH_SLASH) return slc_pkg::LS_TRAIL_COMMENT;
				return slc_pkg::LS_CODE;
			end
			slc_pkg::LS_TRAIL_COMMENT:
				return (c == slc_pkg::CH_NL) ? slc_pkg::LS_NEW_LINE : slc_pkg::LS_TRAIL_COMMENT;
			default: begin
				if (c == slc_pkg::CH_NL) return slc_pkg::LS_NEW_LINE_NC;
				if (c == slc_pkg::CH_SPACE || (c >= slc_pkg::CH_TAB && c <= slc_pkg::CH_CR))
					return slc_pkg::LS_NEW_LINE;
				if (c == slc_pkg::CH_SLASH) return slc_pkg::LS_POS_COMMENT;
				if (c == slc_pkg::CH_HASH) return slc_pkg::LS_DIRECTIVE;
				if (c == slc_pkg::CH_LBRACE) return slc_pkg::LS_OPEN_BRACE;
				if (c == slc_pkg::CH_RBRACE) return slc_pkg::LS_CLOSE_BRACE1;
				return slc_pkg::LS_CODE;
			end
		endcase
	endfunction

	// line rules on the first character of the line; returns 1 when a function closes
	function automatic bit finish_line(output logic [CW-1:0] fl);
		logic [7:0] c;
		bit         closed;
		c = cm_first;
		closed = 1'b0;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
			cm_func = slc_pkg::FS_POSSIBLE;
			cm_fn_lines = '0;
		end
		if (cm_func == slc_pkg::FS_POSSIBLE) begin
			if (c == slc_pkg::CH_LBRACE) begin
				cm_func = slc_pkg::FS_INSIDE;
				cm_found = bump(cm_found);
			end else if (c == slc_pkg::CH_RBRACE) begin
				cm_func = slc_pkg::FS_NONE;
			end
		end
		if (cm_state == slc_pkg::LS_NEW_LINE) begin
			cm_prog_sum = bump(cm_prog_sum);
			if (cm_func == slc_pkg::FS_INSIDE) begin
				cm_fn_lines = bump(cm_fn_lines);
				cm_fn_sum = bump(cm_fn_sum);
			end
		end
		if (cm_state == slc_pkg::LS_NEW_LINE_NC)
			cm_state = slc_pkg::LS_NEW_LINE;
		fl = cm_fn_lines;
		if (cm_func == slc_pkg::FS_INSIDE && c == slc_pkg::CH_RBRACE) begin
			closed = 1'b1;
			cm_func = slc_pkg::FS_NONE;
			cm_fn_lines = '0;
		end
		cm_open = 1'b0;
		return closed;
	endfunction

	function automatic void push_tally(input logic rk, input logic [CW-1:0] fl, input logic last);
		tally_t t;
		t.rk     = rk;
		t.flines = fl;
		t.ftotal = cm_found;
		t.fsum   = cm_fn_sum;
		t.plines = cm_prog_sum;
		t.last   = last;
		pending_tallies.push_back(t);
	endfunction

	function automatic void tally_request(input logic kind, input logic [7:0] b);
		logic [CW-1:0] fl;
		bit            closed;
		closed = 1'b0;
		if (kind == slc_pkg::KIND_BYTE) begin
			if (!cm_open) begin
				cm_first = b;
				cm_open = 1'b1;
			end
			cm_state = next_line_state(cm_state, b);
			if (b == slc_pkg::CH_NL)
				closed = finish_line(fl);
			if (closed)
				push_tally(slc_pkg::RK_RECORD, fl, 1'b1);
		end else begin
			if (cm_open)
				closed = finish_line(fl);
			if (closed)
				push_tally(slc_pkg::RK_RECORD, fl, 1'b0);
			push_tally(slc_pkg::RK_SUMMARY, '0, 1'b1);
			clear_model();
		end
	endfunction

	// called in the time step of a rising edge; leaves valid high after acceptance
	task automatic send_req(input logic kind, input logic [7:0] b);
		bit taken;
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= kind;
		item_ch.byte_value <= b;
		do begin
			@(negedge clk);
			taken = (item_ch.ready === 1'b1);
			if (taken) begin
				tally_request(kind, b);
				requests++;
			end
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_stream();
		foreach (text_q[i])
			send_req(slc_pkg::KIND_BYTE, text_q[i]);
		send_req(slc_pkg::KIND_END, 8'($urandom_range(255)));
		text_q.delete();
	endtask

	task automatic wait_for_results();
		item_ch.valid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(6, 1))
			text_q.push_back(8'($urandom_range(255)));
		if ($urandom_range(1))
			text_q.push_back(slc_pkg::CH_NL);
	endtask

	task automatic gen_program();
		repeat ($urandom_range(6, 2)) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					text_q.push_back($urandom_range(1) ? 8'h41 + 8'($urandom_range(25))
						: 8'h61 + 8'($urandom_range(25)));
					add_text("_fn(void)\n{\n");
					repeat ($urandom_range(4)) begin
						case ($urandom_range(7))
							0: add_text("\tx = y + 1;\n");
							1: add_text("\tif (x) {\n\t\ty--;\n\t}\n");
							2: add_text("\t// note\n");
							3: add_text("\t/* multi\n\t   line **/\n");
							4: add_text("\treturn 0; // done\n");
							5: add_noise();
							6: add_text("#define N 4\n");
							default: add_text("\n");
						endcase
					end
					if ($urandom_range(4) != 0)
						add_text("}\n");
				end
				3: add_text("#include <stdio.h>\n");
				4: add_text("/* block\n * comment */\n");
				5: add_text("// line comment\n");
				6: add_text("int count;  /* trailing */\n");
				7: begin
					if ($urandom_range(1))
						add_text("\n");
					else
						add_text(" \t\n");
				end
				8: add_noise();
				default: add_text("}\n");
			endcase
		end
		// unterminated last line
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(1))
				add_text("}");
			else
				add_text("x = 0;");
		end
	endtask

	task automatic test_function_record();
		add_text("f\n{\n}\n");
		send_stream();
		wait_for_results();
	endtask

	task automatic test_flush_open_line();
		add_text("z\n{\n}");
		send_stream();
		wait_for_results();
	endtask

	task automatic test_char_classes();
		text_q = '{8'h00, 8'hFF, 8'h80, "@", "[", 8'h60, slc_pkg::CH_NL, 8'h0B, 8'h0C,
			slc_pkg::CH_CR, slc_pkg::CH_NL};
		send_stream();
		wait_for_results();
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int n);
		int goal_req;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal_req = requests + n;
		while (requests < goal_req) begin
			gen_program();
			send_stream();
		end
		wait_for_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_req = 120;
		repeat (6) begin
			add_text("g\n{\n}\n");
			send_stream();
		end
		wait_for_results();
	endtask

	// result side ready, with random stalls and long hold-offs
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [CW-1:0] want,
		input logic [CW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(negedge clk) begin : result_check
		tally_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (res_ch.result_kind === slc_pkg::RK_SUMMARY)
				summaries_seen++;
			else
				records_seen++;
			if (pending_tallies.size() == 0) begin
				$error("result with nothing expected: kind %0b program_lines %0d",
					res_ch.result_kind, res_ch.program_lines);
				errors++;
			end else begin
				want = pending_tallies.pop_front();
				check_field("result_kind", CW'(want.rk), CW'(res_ch.result_kind));
				check_field("function_lines", want.flines, res_ch.function_lines);
				check_field("function_total", want.ftotal, res_ch.function_total);
				check_field("lines_in_functions", want.fsum, res_ch.lines_in_functions);
				check_field("program_lines", want.plines, res_ch.program_lines);
				check_field("last", CW'(want.last), CW'(res_ch.last));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: watchdog, %0d cycles with nothing moving, %0d results outstanding",
			quiet, pending_tallies.size());
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.kind       <= slc_pkg::KIND_BYTE;
		item_ch.byte_value <= '0;
		clear_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 70;
		test_function_record();
		test_flush_open_line();
		test_char_classes();
		test_random(22, 70, 290);
		test_random(70, 22, 290);
		test_backpressure();
		test_random(0, 0, 290);

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("tb: %0d requests, %0d function records and %0d summaries checked",
			requests, records_seen, summaries_seen);
		$display("tb: covered comments, directives, braces, odd bytes, open last lines, stalls");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
